@@ sv/utf8sd_pkg.sv @@
// utf8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// Used by utf8_stream_decoder_unit and its port checker; no dependencies.

package utf8sd_pkg;

    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int REM_W   = 2;
    localparam int BYTE_W  = 8;

    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    // byte class boundaries
    localparam logic [BYTE_W-1:0] CONT_LO  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_LO  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] BAD_HI   = 8'hF8;
    localparam logic [BYTE_W-1:0] BAD_C0   = 8'hC0;
    localparam logic [BYTE_W-1:0] BAD_C1   = 8'hC1;

    typedef enum logic {
        ST_OK  = 1'b0,
        ST_BAD = 1'b1
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [CP_W-1:0]   code_point;
        logic [CNT_W-1:0]  byte_count;
        logic              last;
    } result_t;

endpackage

@@ sv/utf8_stream_decoder_unit.sv @@
// utf8_stream_decoder_unit: byte-serial UTF-8 decoder, valid/ready on both sides.
// Depends on utf8sd_pkg (result struct, status codes, range constants).
//
// A result is registered: it shows on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while out_ready holds. Only an ASCII byte that arrives mid-sequence
//   gives two results; it holds the input while the second drains.
// Reset (rst_n low, async): decoder idle, no sequence pending, output empty.

module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // byte input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    // result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [CP_W-1:0]     code_point,
    output logic [CNT_W-1:0]    byte_count,
    output logic                last
);

    // Sequence state
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CP_W-1:0]  pv_reg,   pv_next;

    // Two-entry result buffer: first is what the output shows,
    // second holds the trailing result of a two-result byte.
    result_t first_reg,  first_next;
    result_t second_reg, second_next;
    logic    first_valid_reg,  first_valid_next;
    logic    second_valid_reg, second_valid_next;

    // Decode results for the byte on the port
    result_t r0, r1;
    logic    r0_valid, r1_valid;

    logic             pending;
    logic             is_bad, is_ascii, is_cont;
    logic [CP_W-1:0]  pv_shift;
    logic [CNT_W-1:0] seen_inc;
    logic             cp_illegal;
    logic             in_fire, out_fire;

    assign pending  = (rem_reg != '0);
    assign is_bad   = (data_byte == BAD_C0) || (data_byte == BAD_C1) || (data_byte >= BAD_HI);
    assign is_ascii = (data_byte < CONT_LO);
    assign is_cont  = (data_byte >= CONT_LO) && (data_byte < LEAD_LO);

    // Continuation appends six payload bits; the top ones fall off at 21 bits.
    assign pv_shift   = {pv_reg[CP_W-7:0], data_byte[5:0]};
    assign seen_inc   = seen_reg + CNT_W'(1);
    assign cp_illegal = (pv_shift > CP_MAX) || ((pv_shift >= SURR_LO) && (pv_shift <= SURR_HI));

    // Byte decode: results and next sequence state
    always_comb
    begin
        rem_next  = rem_reg;
        seen_next = seen_reg;
        pv_next   = pv_reg;
        r0_valid  = 1'b0;
        r1_valid  = 1'b0;
        r0        = '{status: ST_BAD, code_point: '0, byte_count: CNT_W'(1), last: 1'b1};
        r1        = '{status: ST_OK,  code_point: '0, byte_count: CNT_W'(1), last: 1'b1};

        if (is_bad)
        begin
            // invalid byte drops itself and whatever was pending
            r0_valid      = 1'b1;
            r0.byte_count = (pending ? seen_reg : '0) + CNT_W'(1);
            rem_next      = '0;
            seen_next     = '0;
            pv_next       = '0;
        end
        else if (is_ascii)
        begin
            if (pending)
            begin
                r0_valid      = 1'b1;
                r0.byte_count = seen_reg;
                r0.last       = 1'b0;
                r1_valid      = 1'b1;
                r1.code_point = CP_W'(data_byte);
            end
            else
            begin
                r0_valid      = 1'b1;
                r0.status     = ST_OK;
                r0.code_point = CP_W'(data_byte);
            end
            rem_next  = '0;
            seen_next = '0;
            pv_next   = '0;
        end
        else if (is_cont)
        begin
            if (!pending)
            begin
                r0_valid = 1'b1;   // stray continuation
            end
            else if (rem_reg == REM_W'(1))
            begin
                // sequence completes
                r0_valid      = 1'b1;
                r0.byte_count = seen_inc;
                if (!cp_illegal)
                begin
                    r0.status     = ST_OK;
                    r0.code_point = pv_shift;
                end
                rem_next  = '0;
                seen_next = '0;
                pv_next   = '0;
            end
            else
            begin
                rem_next  = rem_reg - REM_W'(1);
                seen_next = seen_inc;
                pv_next   = pv_shift;
            end
        end
        else
        begin
            // lead byte: flush any pending sequence, then open a new one
            if (pending)
            begin
                r0_valid      = 1'b1;
                r0.byte_count = seen_reg;
            end
            seen_next = CNT_W'(1);
            if (data_byte < LEAD3_LO)
            begin
                rem_next = REM_W'(1);
                pv_next  = CP_W'(data_byte[4:0]);
            end
            else if (data_byte < LEAD4_LO)
            begin
                rem_next = REM_W'(2);
                pv_next  = CP_W'(data_byte[3:0]);
            end
            else
            begin
                rem_next = REM_W'(3);
                pv_next  = CP_W'(data_byte[2:0]);
            end
        end
    end

    // Take a byte only when both buffer slots will be free after this edge.
    assign in_ready = !second_valid_reg && (!first_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = first_valid_reg && out_ready;

    always_comb
    begin
        first_next        = first_reg;
        second_next       = second_reg;
        first_valid_next  = first_valid_reg;
        second_valid_next = second_valid_reg;
        if (in_fire)
        begin
            first_next        = r0;
            second_next       = r1;
            first_valid_next  = r0_valid;
            second_valid_next = r1_valid;
        end
        else if (out_fire)
        begin
            first_next        = second_reg;
            first_valid_next  = second_valid_reg;
            second_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg          <= '0;
            seen_reg         <= '0;
            pv_reg           <= '0;
            first_valid_reg  <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                rem_reg  <= rem_next;
                seen_reg <= seen_next;
                pv_reg   <= pv_next;
            end
            first_valid_reg  <= first_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign out_valid  = first_valid_reg;
    assign status     = first_reg.status;
    assign code_point = first_reg.code_point;
    assign byte_count = first_reg.byte_count;
    assign last       = first_reg.last;

endmodule

@@ sv/utf8sd_port_checker.sv @@
// utf8sd_port_checker: port-level checks for utf8_stream_decoder_unit.
// Depends on utf8sd_pkg; bound to utf8_stream_decoder_unit at the end of this file.

module utf8sd_port_checker
    import utf8sd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [BYTE_W-1:0] data_byte,
    input logic              out_valid,
    input logic              out_ready,
    input logic              status,
    input logic [CP_W-1:0]   code_point,
    input logic [CNT_W-1:0]  byte_count,
    input logic              last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(code_point)
            && $stable(byte_count) && $stable(last))
        else $error("stalled result changed");

    // a byte is never taken while a shown result is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready)
        else $error("byte accepted over a stalled result");

    // decoded values are legal scalars; malformed results carry zero
    a_cp_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_BAD && code_point == '0)
            || (status == ST_OK && code_point <= CP_MAX
                && !(code_point >= SURR_LO && code_point <= SURR_HI)))
        else $error("illegal code point on output");

    // only a malformed flush can precede another result of the same byte
    a_not_last_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_BAD && byte_count != '0)
        else $error("non-final result is not a malformed flush");

    // byte count within one to four
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count != '0 && byte_count <= CNT_W'(4))
        else $error("byte count out of range");

endmodule

bind utf8_stream_decoder_unit utf8sd_port_checker u_utf8sd_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .code_point (code_point),
    .byte_count (byte_count),
    .last       (last)
);

@@ verif/testbench.sv @@
// testbench: self-checking bench for utf8_stream_decoder_unit (byte in, code point out).
// Depends on utf8sd_pkg for widths, byte class bounds and the result struct;
// predicts each result in-bench and checks it field by field on the output port.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import utf8sd_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte  = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              status;
    logic [CP_W-1:0]   code_point;
    logic [CNT_W-1:0]  byte_count;
    logic              last;

    // Predicted decoder state: continuation bytes still owed, bytes of the
    // open sequence so far, and the code point bits gathered so far.
    logic [REM_W-1:0]  seq_left  = '0;
    logic [CNT_W-1:0]  seq_seen  = '0;
    logic [CP_W-1:0]   seq_value = '0;

    result_t           decoded_q[$];   // results the decoder still owes, oldest first
    int                bytes_sent        = 0;
    int                mismatch_cnt      = 0;
    int                stall_cycles      = 0;
    int                sender_idle_pct   = 0;
    int                receiver_idle_pct = 0;

    utf8_stream_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .code_point (code_point),
        .byte_count (byte_count),
        .last       (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic push_result(input status_t st, input logic [CP_W-1:0] cp,
                               input logic [CNT_W-1:0] cnt, input logic is_last);
        result_t r;
        r.status     = st;
        r.code_point = (st == ST_OK) ? cp : '0;
        r.byte_count = cnt;
        r.last       = is_last;
        decoded_q.push_back(r);
    endtask

    task automatic drop_sequence();
        seq_left  = '0;
        seq_seen  = '0;
        seq_value = '0;
    endtask

    // Works out what one accepted byte makes the decoder emit, and advances
    // the predicted state.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic open_seq;
        open_seq = (seq_left != '0);
        if (b == BAD_C0 || b == BAD_C1 || b >= BAD_HI)
        begin
            // never legal: swallows any open sequence along with itself
            push_result(ST_BAD, '0, (open_seq ? seq_seen : CNT_W'(0)) + CNT_W'(1), 1'b1);
            drop_sequence();
        end
        else if (b < CONT_LO)
        begin
            // ASCII: an open sequence is flushed first, then the byte itself
            if (open_seq)
            begin
                push_result(ST_BAD, '0, seq_seen, 1'b0);
                drop_sequence();
            end
            push_result(ST_OK, CP_W'(b), CNT_W'(1), 1'b1);
        end
        else if (b < LEAD_LO)
        begin
            if (!open_seq)
                push_result(ST_BAD, '0, CNT_W'(1), 1'b1);   // stray continuation
            else
            begin
                seq_value = {seq_value[CP_W-7:0], b[5:0]};
                seq_seen  = seq_seen + CNT_W'(1);
                seq_left  = seq_left - REM_W'(1);
                if (seq_left == '0)
                begin
                    if (seq_value > CP_MAX || (seq_value >= SURR_LO && seq_value <= SURR_HI))
                        push_result(ST_BAD, '0, seq_seen, 1'b1);
                    else
                        push_result(ST_OK, seq_value, seq_seen, 1'b1);
                    drop_sequence();
                end
            end
        end
        else
        begin
            // lead byte: flush an open sequence, then start a new one
            if (open_seq)
            begin
                push_result(ST_BAD, '0, seq_seen, 1'b1);
                drop_sequence();
            end
            if (b < LEAD3_LO)
            begin
                seq_left  = REM_W'(1);
                seq_value = CP_W'(b[4:0]);
            end
            else if (b < LEAD4_LO)
            begin
                seq_left  = REM_W'(2);
                seq_value = CP_W'(b[3:0]);
            end
            else
            begin
                seq_left  = REM_W'(3);
                seq_value = CP_W'(b[2:0]);
            end
            seq_seen = CNT_W'(1);
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Presents one item and holds it until taken. Called at a clock edge.
    // Valid stays up when the next item follows at once, so it is never
    // dropped and raised within one step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
    endtask

    // Sender holds off until every owed result has come out.
    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_t exp_r;
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: status %0d code_point %h byte_count %0d last %0d",
                       status, code_point, byte_count, last);
                mismatch_cnt++;
            end
            else
            begin
                exp_r = decoded_q.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    mismatch_cnt++;
                end
                if (code_point !== exp_r.code_point)
                begin
                    $error("code_point: expected %h, got %h", exp_r.code_point, code_point);
                    mismatch_cnt++;
                end
                if (byte_count !== exp_r.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d", exp_r.byte_count, byte_count);
                    mismatch_cnt++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, got %0d", exp_r.last, last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: a hang on either side shows up as a long run of dead cycles.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single-byte cases: ASCII bounds, bytes that are never legal, a stray
    // continuation with nothing open.
    task automatic test_single_bytes();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hC1);
        send_byte(8'hFF);
        send_byte(8'hBF);
    endtask

    // Complete sequences: 2-byte top, overlong 3-byte (accepted), largest
    // scalar, just past it, and a surrogate.
    task automatic test_full_sequences();
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
    endtask

    // Sequences cut short by ASCII (two results from one byte), by a new
    // lead byte, and by an illegal byte.
    task automatic test_broken_sequences();
        send_byte(8'hE2); send_byte(8'h41);
        send_byte(8'hF0); send_byte(8'hC2); send_byte(8'h80);
        send_byte(8'hF0); send_byte(8'h90); send_byte(8'hF8);
    endtask

    // Mostly well-formed sequences with random content; some truncated,
    // some pure noise bytes that reach every bit pattern.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bytes);
        int                stop_at;
        int                pick;
        int                seq_len;
        int                cut;
        logic [BYTE_W-1:0] lead;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_byte(BYTE_W'($urandom_range(8'h7F, 8'h00)));
            else if (pick < 85)
            begin
                seq_len = $urandom_range(4, 2);
                cut = (pick >= 77) ? $urandom_range(seq_len - 1, 1) : seq_len;
                case (seq_len)
                    2:       lead = BYTE_W'($urandom_range(8'hDF, 8'hC2));
                    3:       lead = BYTE_W'($urandom_range(8'hEF, 8'hE0));
                    default: lead = BYTE_W'($urandom_range(8'hF7, 8'hF0));
                endcase
                send_byte(lead);
                for (int i = 1; i < cut; i++)
                    send_byte(BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
            else
                send_byte(BYTE_W'($urandom()));
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 31;
        receiver_idle_pct = 81;
        test_single_bytes();
        test_full_sequences();
        test_broken_sequences();
        wait_drained();

        test_random_traffic(31, 81, 250);
        test_random_traffic(81, 31, 250);
        test_random_traffic(0, 0, 250);

        // outputs are given time to settle, then the verdict
        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/utf8sd_pkg.sv
sv/utf8_stream_decoder_unit.sv
sv/utf8sd_port_checker.sv
verif/testbench.sv
